// ===== hdl/fvn_pkg.sv =====
`default_nettype none

package fvn_pkg;

    // build-time defaults for the top-level parameters
    localparam int MAX_OCTAVES_DEF     = 8;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // field widths
    localparam int COORD_W   = 24;
    localparam int CNT_W     = 4;
    localparam int NOISE_W   = 39;
    localparam int OCT_VAL_W = 32;
    localparam int SUM_W     = 40;
    localparam int PROD_W    = 57;

    // octave slots in the adder tree, largest octave count supported
    localparam int OCT_SLOTS       = 8;
    localparam int TOP_WEIGHT_LOG2 = 7;

    // pipeline depth: four hash stages, two adder stages, one scale stage
    localparam int LANE_STAGES = 4;
    localparam int NUM_STAGES  = 7;

    localparam logic [CNT_W-1:0] OCT_CNT_RESET = 4'd5;

    // integer hash constants
    localparam logic [31:0] HASH_MUL_Y     = 32'd57;
    localparam logic [31:0] HASH_MUL_SEED  = 32'd131;
    localparam int          HASH_SEED_STEP = 7;
    localparam logic [31:0] HASH_C1        = 32'd15731;
    localparam logic [31:0] HASH_C2        = 32'd789221;
    localparam logic [31:0] HASH_C3        = 32'd1376312589;
    localparam logic [31:0] ONE_Q30        = 32'h4000_0000;

    // 0.6 in Q0.16
    localparam logic signed [PROD_W-1:0] SCALE_Q16 = 57'sd39322;
    localparam int SCALE_SHIFT = 16;

    typedef logic [COORD_W-1:0]          t_coord;
    typedef logic signed [OCT_VAL_W-1:0] t_oct_val;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic signed [NOISE_W-1:0]   t_noise;

endpackage

`default_nettype wire

// ===== hdl/fvn_in_if.sv =====
`default_nettype none

interface fvn_in_if
    import fvn_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord coord_x;
    t_coord coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/fvn_out_if.sv =====
`default_nettype none

interface fvn_out_if
    import fvn_pkg::*;
();
    logic   valid;
    logic   ready;
    t_noise noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/fvn_octave.sv =====
`default_nettype none

module fvn_octave
    import fvn_pkg::*;
#(
    parameter int OCTAVE          = 0,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic [LANE_STAGES-1:0] i_stage_en,
    input  wire t_coord                 i_coord_x,
    input  wire t_coord                 i_coord_y,
    output t_oct_val                    o_value
);

    localparam logic [31:0] SEED_TERM = 32'(OCTAVE * HASH_SEED_STEP) * HASH_MUL_SEED;

    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] n_base;
    logic [31:0] n_n1;
    logic [31:0] n_h;

    logic [31:0] r_n1;
    logic [31:0] r_n2;
    logic [31:0] r_n3;
    logic [31:0] r_sq;
    logic [31:0] r_t;
    t_oct_val    r_v;

    // integer lattice coordinates at this octave's frequency
    always_comb begin
        hx     = (32'(i_coord_x) << OCTAVE) >> COORD_FRAC_BITS;
        hy     = (32'(i_coord_y) << OCTAVE) >> COORD_FRAC_BITS;
        n_base = hx + hy * HASH_MUL_Y + SEED_TERM;
        n_n1   = (n_base << 13) ^ n_base;
        n_h    = (r_n3 * r_t + HASH_C3) & 32'h7FFF_FFFF;
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_n1 <= n_n1;
        end
        if (i_stage_en[1]) begin
            r_sq <= r_n1 * r_n1;
            r_n2 <= r_n1;
        end
        if (i_stage_en[2]) begin
            r_t  <= r_sq * HASH_C1 + HASH_C2;
            r_n3 <= r_n2;
        end
        if (i_stage_en[3]) begin
            r_v <= t_oct_val'(ONE_Q30 - n_h);
        end
    end

    assign o_value = r_v;

endmodule

`default_nettype wire

// ===== hdl/fractal_value_noise.sv =====
`default_nettype none

// stages: four hash stages per octave lane, two adder-tree stages, one scale
//   stage that is the output register; all octaves run in parallel lanes
// throughput: one transaction per cycle while the output is not stalled
// a stalled output holds its stage and bubbles ahead of it still close up
// reset (synchronous, active low) clears all valid bits and sets octave_count to 5

module fractal_value_noise
    import fvn_pkg::*;
#(
    parameter int MAX_OCTAVES     = MAX_OCTAVES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_data,
    fvn_in_if.sink                i_in,
    fvn_out_if.source             o_out
);

    logic [CNT_W-1:0]      r_octave_count;
    logic [CNT_W-1:0]      cnt_eff;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_en;

    t_oct_val lane_v [OCT_SLOTS];
    t_sum     term   [OCT_SLOTS];
    t_sum     n_pair [OCT_SLOTS/2];
    t_sum     r_pair [OCT_SLOTS/2];
    t_sum     n_sum;
    t_sum     r_sum;
    logic signed [PROD_W-1:0] prod;
    t_noise   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= OCT_CNT_RESET;
        end else if (i_cfg_we) begin
            r_octave_count <= i_cfg_data;
        end
    end

    assign cnt_eff = (r_octave_count > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES)
                                                            : r_octave_count;

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_out.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = stage_en[0];

    for (genvar g = 0; g < OCT_SLOTS; g++) begin : g_lane
        if (g < MAX_OCTAVES) begin : g_used
            fvn_octave #(
                .OCTAVE          (g),
                .COORD_FRAC_BITS (COORD_FRAC_BITS)
            ) u_octave (
                .i_clk      (i_clk),
                .i_stage_en (stage_en[LANE_STAGES-1:0]),
                .i_coord_x  (i_in.coord_x),
                .i_coord_y  (i_in.coord_y),
                .o_value    (lane_v[g])
            );
        end else begin : g_unused
            assign lane_v[g] = '0;
        end
    end

    // weight 2^(7-i), octaves past the count drop out
    always_comb begin
        for (int i = 0; i < OCT_SLOTS; i++) begin
            if (CNT_W'(i) < cnt_eff) begin
                term[i] = SUM_W'(lane_v[i]) <<< (TOP_WEIGHT_LOG2 - i);
            end else begin
                term[i] = '0;
            end
        end
        for (int j = 0; j < OCT_SLOTS / 2; j++) begin
            n_pair[j] = term[2*j] + term[2*j+1];
        end
        n_sum = (r_pair[0] + r_pair[1]) + (r_pair[2] + r_pair[3]);
        prod  = PROD_W'(r_sum) * SCALE_Q16;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[LANE_STAGES]) begin
            r_pair <= n_pair;
        end
        if (stage_en[LANE_STAGES+1]) begin
            r_sum <= n_sum;
        end
        // arithmetic shift floors, matching the rounding toward minus infinity
        if (stage_en[LANE_STAGES+2]) begin
            r_out <= prod[SCALE_SHIFT +: NOISE_W];
        end
    end

    assign o_out.valid       = r_vld[NUM_STAGES-1];
    assign o_out.noise_value = r_out;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted transaction did not enter the first stage");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> ((&r_vld) && !o_out.ready))
        else $error("input stalled while the pipeline had room");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_octave_count == $past(i_cfg_data)))
        else $error("octave count write lost");
`endif

endmodule

`default_nettype wire
